// ===== src/assert_macros.svh =====
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define FOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FOP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fop_pkg.sv =====
// ------------------------------------------------------------------------
// fop_pkg
// Shared constants, operand codes, microcode table and command types for
// the face occlusion point test.
// ------------------------------------------------------------------------
package fop_pkg;

    localparam int MAX_FACE_VERTICES = 32;
    localparam int COORD_FRAC_BITS   = 16;

    localparam int CW    = 32;
    localparam int IDXW  = $clog2(MAX_FACE_VERTICES);
    localparam int CNTW  = $clog2(MAX_FACE_VERTICES + 1);
    localparam int SUMW  = CW + CNTW;
    localparam int EW    = SUMW + 2;
    localparam int TOLW  = 16;
    localparam int TOL_RESET_INT = (2 ** COORD_FRAC_BITS + 5000) / 10000;
    localparam logic [TOLW-1:0] TOL_RESET = TOLW'(TOL_RESET_INT);

    // multiplier datapath widths
    localparam int DW         = 8;
    localparam int AW         = 144;
    localparam int BW         = 72;
    localparam int PW         = 184;
    localparam int NDIG_LONG  = BW / DW;
    localparam int NDIG_SHORT = 5;
    localparam int SHORTW     = NDIG_SHORT * DW;
    localparam int DIGCW      = $clog2(NDIG_LONG + 1);
    localparam int LW         = 2 * (CW + 1) + 2;
    localparam int DDW        = LW + CW + 4;
    localparam int SW         = 2 * LW + 4;

    // operand codes
    localparam int OSW = 5;
    localparam logic [OSW-1:0] OPD_Y01 = 5'd0;
    localparam logic [OSW-1:0] OPD_Z12 = 5'd1;
    localparam logic [OSW-1:0] OPD_Y12 = 5'd2;
    localparam logic [OSW-1:0] OPD_Z01 = 5'd3;
    localparam logic [OSW-1:0] OPD_X12 = 5'd4;
    localparam logic [OSW-1:0] OPD_X01 = 5'd5;
    localparam logic [OSW-1:0] OPD_PX0 = 5'd6;
    localparam logic [OSW-1:0] OPD_PY0 = 5'd7;
    localparam logic [OSW-1:0] OPD_PZ0 = 5'd8;
    localparam logic [OSW-1:0] OPD_L   = 5'd9;
    localparam logic [OSW-1:0] OPD_M   = 5'd10;
    localparam logic [OSW-1:0] OPD_N   = 5'd11;
    localparam logic [OSW-1:0] OPD_D   = 5'd12;
    localparam logic [OSW-1:0] OPD_S   = 5'd13;
    localparam logic [OSW-1:0] OPD_TOL = 5'd14;
    localparam logic [OSW-1:0] OPD_CXI = 5'd15;
    localparam logic [OSW-1:0] OPD_CYK = 5'd16;
    localparam logic [OSW-1:0] OPD_CXK = 5'd17;
    localparam logic [OSW-1:0] OPD_CYI = 5'd18;
    localparam logic [OSW-1:0] OPD_PXI = 5'd19;
    localparam logic [OSW-1:0] OPD_PYK = 5'd20;
    localparam logic [OSW-1:0] OPD_PXK = 5'd21;
    localparam logic [OSW-1:0] OPD_PYI = 5'd22;

    // accumulator destinations
    localparam logic [2:0] DST_L  = 3'd0;
    localparam logic [2:0] DST_M  = 3'd1;
    localparam logic [2:0] DST_N  = 3'd2;
    localparam logic [2:0] DST_D  = 3'd3;
    localparam logic [2:0] DST_S  = 3'd4;
    localparam logic [2:0] DST_T  = 3'd5;
    localparam logic [2:0] DST_CA = 3'd6;
    localparam logic [2:0] DST_PA = 3'd7;

    typedef struct packed {
        logic [OSW-1:0] a_sel;
        logic [OSW-1:0] b_sel;
        logic           neg;
        logic           long_b;
        logic           last;
        logic [2:0]     dst;
    } fop_op_t;

    localparam int OPIW     = 5;
    localparam int EDGE_OP0 = 14;

    // multiply-accumulate microcode: plane terms, then one edge
    function automatic fop_op_t fop_op_rom(input logic [OPIW-1:0] idx);
        fop_op_t op;
        op = '0;
        case (idx)
            5'd0:  op = '{OPD_Y01, OPD_Z12, 1'b0, 1'b0, 1'b0, DST_L};
            5'd1:  op = '{OPD_Y12, OPD_Z01, 1'b1, 1'b0, 1'b1, DST_L};
            5'd2:  op = '{OPD_Z01, OPD_X12, 1'b0, 1'b0, 1'b0, DST_M};
            5'd3:  op = '{OPD_Z12, OPD_X01, 1'b1, 1'b0, 1'b1, DST_M};
            5'd4:  op = '{OPD_X01, OPD_Y12, 1'b0, 1'b0, 1'b0, DST_N};
            5'd5:  op = '{OPD_X12, OPD_Y01, 1'b1, 1'b0, 1'b1, DST_N};
            5'd6:  op = '{OPD_L,   OPD_PX0, 1'b0, 1'b0, 1'b0, DST_D};
            5'd7:  op = '{OPD_M,   OPD_PY0, 1'b0, 1'b0, 1'b0, DST_D};
            5'd8:  op = '{OPD_N,   OPD_PZ0, 1'b0, 1'b0, 1'b1, DST_D};
            5'd9:  op = '{OPD_L,   OPD_L,   1'b0, 1'b1, 1'b0, DST_S};
            5'd10: op = '{OPD_M,   OPD_M,   1'b0, 1'b1, 1'b0, DST_S};
            5'd11: op = '{OPD_N,   OPD_N,   1'b0, 1'b1, 1'b1, DST_S};
            5'd12: op = '{OPD_D,   OPD_N,   1'b0, 1'b1, 1'b0, DST_T};
            5'd13: op = '{OPD_S,   OPD_TOL, 1'b0, 1'b0, 1'b1, DST_T};
            5'd14: op = '{OPD_CXI, OPD_CYK, 1'b0, 1'b0, 1'b0, DST_CA};
            5'd15: op = '{OPD_CXK, OPD_CYI, 1'b1, 1'b0, 1'b1, DST_CA};
            5'd16: op = '{OPD_PXI, OPD_PYK, 1'b0, 1'b0, 1'b0, DST_PA};
            5'd17: op = '{OPD_PXK, OPD_PYI, 1'b1, 1'b0, 1'b1, DST_PA};
            default: op = '0;
        endcase
        return op;
    endfunction

    typedef struct packed {
        logic            load_vertex;
        logic            new_face;
        logic            latch_point;
        logic            mem_re;
        logic [IDXW-1:0] mem_raddr;
        logic            cap_v0;
        logic            cap_vi;
        logic            cap_vk;
        logic            copy_v0_vi;
        logic            copy_v0_vk;
        logic            copy_vk_vi;
        logic            op_load;
        logic [OSW-1:0]  a_sel;
        logic [OSW-1:0]  b_sel;
        logic            long_b;
        logic            op_step;
        logic            op_acc;
        logic            neg;
        logic            store;
        logic [2:0]      dst;
    } fop_cmd_t;

    typedef struct packed {
        logic [CNTW-1:0] count;
        logic            plane_hit;
        logic            edge_hit;
    } fop_stat_t;

endpackage

// ===== src/fop_ifs.sv =====
// ------------------------------------------------------------------------
// fop channel interfaces
// Valid/ready channels for input items, results and configuration.
// ------------------------------------------------------------------------
interface fop_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic        new_face;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    modport source (output valid, action, new_face, coord_x, coord_y, coord_z, input ready);
    modport sink (input valid, action, new_face, coord_x, coord_y, coord_z, output ready);
endinterface

interface fop_out_if;
    logic valid;
    logic ready;
    logic visible;
    logic face_error;
    modport source (output valid, visible, face_error, input ready);
    modport sink (input valid, visible, face_error, output ready);
endinterface

interface fop_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] above_tolerance;
    modport source (output valid, above_tolerance, input ready);
    modport sink (input valid, above_tolerance, output ready);
endinterface

// ===== src/fop_datapath.sv =====
// ------------------------------------------------------------------------
// fop_datapath
// Vertex store, running sums, operand selection, digit-serial multiplier
// with accumulator and the plane/edge result registers.
// ------------------------------------------------------------------------
module fop_datapath
    import fop_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  fop_cmd_t        cmd,
    input  logic [CW-1:0]   coord_x,
    input  logic [CW-1:0]   coord_y,
    input  logic [CW-1:0]   coord_z,
    input  logic            cfg_we,
    input  logic [TOLW-1:0] cfg_data,
    output fop_stat_t       stat
);

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } fop_vtx_t;

    fop_vtx_t mem [MAX_FACE_VERTICES];
    fop_vtx_t rd_q_reg;
    fop_vtx_t v0_reg, vi_reg, vk_reg;

    logic [TOLW-1:0]        tol_reg;
    logic [CNTW-1:0]        count_reg, count_next;
    logic signed [SUMW-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUMW-1:0] sum_x_next, sum_y_next, sum_z_next;
    logic signed [CW-1:0]   px_reg, py_reg, pz_reg;

    logic signed [AW-1:0]   a_reg;
    logic [BW-1:0]          b_reg;
    logic                   first_reg;
    logic signed [PW-1:0]   p_reg, p_next;
    logic signed [PW-1:0]   acc_reg;
    logic signed [LW-1:0]   l_reg, m_reg, n_reg;
    logic signed [DDW-1:0]  d_reg;
    logic signed [SW-1:0]   s_reg;
    logic                   s_zero_reg, ca_neg_reg, ca_zero_reg;

    logic                   wr_ok;
    logic [IDXW-1:0]        wr_idx;
    logic signed [AW-1:0]   a_val, b_val;
    logic signed [DW:0]     dsig;
    logic signed [AW+DW:0]  prod;
    logic                   acc_zero;

    function automatic logic signed [CW:0] sub33(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
        return $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    // coordinate sum minus count-scaled vertex coordinate
    function automatic logic signed [EW-1:0] csub(input logic signed [SUMW-1:0] s,
                                                  input logic [CNTW-1:0] n,
                                                  input logic signed [CW-1:0] v);
        logic signed [CW+CNTW:0] nv;
        nv = $signed({1'b0, n}) * v;
        return $signed({{2{s[SUMW-1]}}, s}) - $signed({nv[CW+CNTW], nv});
    endfunction

    function automatic logic signed [AW-1:0] opnd(input logic [OSW-1:0] sel);
        logic signed [AW-1:0] r;
        r = '0;
        case (sel)
            OPD_Y01: r = AW'(sub33(v0_reg.y, vi_reg.y));
            OPD_Z12: r = AW'(sub33(vi_reg.z, vk_reg.z));
            OPD_Y12: r = AW'(sub33(vi_reg.y, vk_reg.y));
            OPD_Z01: r = AW'(sub33(v0_reg.z, vi_reg.z));
            OPD_X12: r = AW'(sub33(vi_reg.x, vk_reg.x));
            OPD_X01: r = AW'(sub33(v0_reg.x, vi_reg.x));
            OPD_PX0: r = AW'(sub33(px_reg, v0_reg.x));
            OPD_PY0: r = AW'(sub33(py_reg, v0_reg.y));
            OPD_PZ0: r = AW'(sub33(pz_reg, v0_reg.z));
            OPD_L:   r = AW'(l_reg);
            OPD_M:   r = AW'(m_reg);
            OPD_N:   r = AW'(n_reg);
            OPD_D:   r = AW'(d_reg);
            OPD_S:   r = AW'(s_reg);
            OPD_TOL: r = AW'($signed({1'b0, tol_reg}));
            OPD_CXI: r = AW'(csub(sum_x_reg, count_reg, vi_reg.x));
            OPD_CYK: r = AW'(csub(sum_y_reg, count_reg, vk_reg.y));
            OPD_CXK: r = AW'(csub(sum_x_reg, count_reg, vk_reg.x));
            OPD_CYI: r = AW'(csub(sum_y_reg, count_reg, vi_reg.y));
            OPD_PXI: r = AW'(sub33(px_reg, vi_reg.x));
            OPD_PYK: r = AW'(sub33(py_reg, vk_reg.y));
            OPD_PXK: r = AW'(sub33(px_reg, vk_reg.x));
            OPD_PYI: r = AW'(sub33(py_reg, vi_reg.y));
            default: r = '0;
        endcase
        return r;
    endfunction

    // vertex append bookkeeping
    always_comb
    begin
        wr_ok      = cmd.new_face || (count_reg < CNTW'(MAX_FACE_VERTICES));
        wr_idx     = cmd.new_face ? '0 : count_reg[IDXW-1:0];
        count_next = (cmd.new_face ? '0 : count_reg) + CNTW'(1);
        sum_x_next = (cmd.new_face ? '0 : sum_x_reg) + SUMW'($signed(coord_x));
        sum_y_next = (cmd.new_face ? '0 : sum_y_reg) + SUMW'($signed(coord_y));
        sum_z_next = (cmd.new_face ? '0 : sum_z_reg) + SUMW'($signed(coord_z));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            tol_reg   <= TOL_RESET;
        end
        else
        begin
            if (cmd.load_vertex && wr_ok)
            begin
                count_reg <= count_next;
                sum_x_reg <= sum_x_next;
                sum_y_reg <= sum_y_next;
                sum_z_reg <= sum_z_next;
            end
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    // vertex memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_vertex && wr_ok)
        begin
            mem[wr_idx] <= '{$signed(coord_x), $signed(coord_y), $signed(coord_z)};
        end
        if (cmd.mem_re)
        begin
            rd_q_reg <= mem[cmd.mem_raddr];
        end
    end

    // vertex and point holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_point)
        begin
            px_reg <= $signed(coord_x);
            py_reg <= $signed(coord_y);
            pz_reg <= $signed(coord_z);
        end
        if (cmd.cap_v0)
        begin
            v0_reg <= rd_q_reg;
        end
        if (cmd.cap_vi)
        begin
            vi_reg <= rd_q_reg;
        end
        else if (cmd.copy_v0_vi)
        begin
            vi_reg <= v0_reg;
        end
        else if (cmd.copy_vk_vi)
        begin
            vi_reg <= vk_reg;
        end
        if (cmd.cap_vk)
        begin
            vk_reg <= rd_q_reg;
        end
        else if (cmd.copy_v0_vk)
        begin
            vk_reg <= v0_reg;
        end
    end

    // Horner multiplier, one 8-bit digit of B per cycle, MSB first; top digit signed, rest unsigned
    always_comb
    begin
        a_val  = opnd(cmd.a_sel);
        b_val  = opnd(cmd.b_sel);
        dsig   = first_reg ? $signed({b_reg[BW-1], b_reg[BW-1 -: DW]})
                           : $signed({1'b0, b_reg[BW-1 -: DW]});
        prod   = a_reg * dsig;
        p_next = (p_reg <<< DW) + PW'(prod);
        acc_zero = (acc_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
        begin
            a_reg     <= a_val;
            b_reg     <= cmd.long_b ? b_val[BW-1:0]
                                    : {b_val[SHORTW-1:0], {(BW-SHORTW){1'b0}}};
            p_reg     <= '0;
            first_reg <= 1'b1;
        end
        else if (cmd.op_step)
        begin
            p_reg     <= p_next;
            b_reg     <= b_reg << DW;
            first_reg <= 1'b0;
        end
    end

    // accumulator and term registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (cmd.op_acc)
        begin
            acc_reg <= cmd.neg ? acc_reg - p_reg : acc_reg + p_reg;
        end
        else if (cmd.store)
        begin
            acc_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            case (cmd.dst)
                DST_L: l_reg <= acc_reg[LW-1:0];
                DST_M: m_reg <= acc_reg[LW-1:0];
                DST_N: n_reg <= acc_reg[LW-1:0];
                DST_D: d_reg <= acc_reg[DDW-1:0];
                DST_S:
                begin
                    s_reg      <= acc_reg[SW-1:0];
                    s_zero_reg <= acc_zero;
                end
                DST_CA:
                begin
                    ca_neg_reg  <= acc_reg[PW-1];
                    ca_zero_reg <= acc_zero;
                end
                default: ;
            endcase
        end
    end

    // decisions read the accumulator before it is cleared
    assign stat.count     = count_reg;
    assign stat.plane_hit = !s_zero_reg && !acc_reg[PW-1];
    assign stat.edge_hit  = ca_zero_reg || acc_zero || (ca_neg_reg != acc_reg[PW-1]);

endmodule

// ===== src/fop_ctrl.sv =====
// ------------------------------------------------------------------------
// fop_ctrl
// Sequencer: input handshake, vertex fetch, microcode walk of the
// multiply-accumulate steps, edge loop and result register.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module fop_ctrl
    import fop_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_action,
    input  logic      in_new_face,
    output logic      in_ready,
    input  fop_stat_t stat,
    output fop_cmd_t  cmd,
    output logic      out_valid,
    output logic      out_visible,
    output logic      out_face_error,
    input  logic      out_ready
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_RD0    = 4'd1;
    localparam logic [3:0] ST_RD1    = 4'd2;
    localparam logic [3:0] ST_RD2    = 4'd3;
    localparam logic [3:0] ST_CAP2   = 4'd4;
    localparam logic [3:0] ST_OPLD   = 4'd5;
    localparam logic [3:0] ST_OPSTEP = 4'd6;
    localparam logic [3:0] ST_OPACC  = 4'd7;
    localparam logic [3:0] ST_STORE  = 4'd8;
    localparam logic [3:0] ST_EDGE0  = 4'd9;
    localparam logic [3:0] ST_ERD    = 4'd10;
    localparam logic [3:0] ST_ECAP   = 4'd11;
    localparam logic [3:0] ST_RESULT = 4'd12;

    logic [3:0]      state_reg, state_next;
    logic [OPIW-1:0] opi_reg, opi_next;
    logic [DIGCW-1:0] dig_reg, dig_next;
    logic [IDXW-1:0] edge_reg, edge_next;
    logic            vis_reg, vis_next;
    logic            err_reg, err_next;
    logic            out_valid_reg, out_visible_reg, out_error_reg;
    logic            out_load;
    logic            in_accept;
    logic [CNTW-1:0] k_idx;
    fop_op_t         op;

    assign op        = fop_op_rom(opi_reg);
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign k_idx     = {1'b0, edge_reg} + CNTW'(1);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        opi_next   = opi_reg;
        dig_next   = dig_reg;
        edge_next  = edge_reg;
        vis_next   = vis_reg;
        err_next   = err_reg;
        out_load   = 1'b0;
        cmd        = '0;
        cmd.a_sel  = op.a_sel;
        cmd.b_sel  = op.b_sel;
        cmd.long_b = op.long_b;
        cmd.neg    = op.neg;
        cmd.dst    = op.dst;
        cmd.new_face = in_new_face;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!in_action)
                    begin
                        cmd.load_vertex = 1'b1;
                    end
                    else
                    begin
                        cmd.latch_point = 1'b1;
                        if (stat.count < CNTW'(3))
                        begin
                            vis_next   = 1'b0;
                            err_next   = 1'b1;
                            state_next = ST_RESULT;
                        end
                        else
                        begin
                            state_next = ST_RD0;
                        end
                    end
                end
            end
            ST_RD0:
            begin
                cmd.mem_re    = 1'b1;
                cmd.mem_raddr = IDXW'(0);
                state_next    = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.cap_v0    = 1'b1;
                cmd.mem_re    = 1'b1;
                cmd.mem_raddr = IDXW'(1);
                state_next    = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.cap_vi    = 1'b1;
                cmd.mem_re    = 1'b1;
                cmd.mem_raddr = IDXW'(2);
                state_next    = ST_CAP2;
            end
            ST_CAP2:
            begin
                cmd.cap_vk = 1'b1;
                opi_next   = '0;
                state_next = ST_OPLD;
            end
            ST_OPLD:
            begin
                cmd.op_load = 1'b1;
                dig_next    = op.long_b ? DIGCW'(NDIG_LONG) : DIGCW'(NDIG_SHORT);
                state_next  = ST_OPSTEP;
            end
            ST_OPSTEP:
            begin
                cmd.op_step = 1'b1;
                dig_next    = dig_reg - DIGCW'(1);
                if (dig_reg == DIGCW'(1))
                begin
                    state_next = ST_OPACC;
                end
            end
            ST_OPACC:
            begin
                cmd.op_acc = 1'b1;
                if (op.last)
                begin
                    state_next = ST_STORE;
                end
                else
                begin
                    opi_next   = opi_reg + OPIW'(1);
                    state_next = ST_OPLD;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (op.dst == DST_T)
                begin
                    if (stat.plane_hit)
                    begin
                        vis_next   = 1'b1;
                        err_next   = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_EDGE0;
                    end
                end
                else if (op.dst == DST_PA)
                begin
                    err_next = 1'b0;
                    if (stat.edge_hit)
                    begin
                        vis_next   = 1'b1;
                        state_next = ST_RESULT;
                    end
                    else if (k_idx == stat.count)
                    begin
                        vis_next   = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        cmd.copy_vk_vi = 1'b1;
                        edge_next      = k_idx[IDXW-1:0];
                        state_next     = ST_ERD;
                    end
                end
                else
                begin
                    opi_next   = opi_reg + OPIW'(1);
                    state_next = ST_OPLD;
                end
            end
            ST_EDGE0:
            begin
                cmd.copy_v0_vi = 1'b1;
                edge_next      = '0;
                state_next     = ST_ERD;
            end
            ST_ERD:
            begin
                opi_next = OPIW'(EDGE_OP0);
                if (k_idx == stat.count)
                begin
                    cmd.copy_v0_vk = 1'b1;
                    state_next     = ST_OPLD;
                end
                else
                begin
                    cmd.mem_re    = 1'b1;
                    cmd.mem_raddr = k_idx[IDXW-1:0];
                    state_next    = ST_ECAP;
                end
            end
            ST_ECAP:
            begin
                cmd.cap_vk = 1'b1;
                state_next = ST_OPLD;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            opi_reg       <= '0;
            dig_reg       <= '0;
            edge_reg      <= '0;
            vis_reg       <= 1'b0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            opi_reg   <= opi_next;
            dig_reg   <= dig_next;
            edge_reg  <= edge_next;
            vis_reg   <= vis_next;
            err_reg   <= err_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_visible_reg <= vis_reg;
            out_error_reg   <= err_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_visible    = out_visible_reg;
    assign out_face_error = out_error_reg;

    `FOP_ASSERT(a_rd_in_face, !cmd.mem_re || ({1'b0, cmd.mem_raddr} < stat.count), "read past face")
    `FOP_ASSERT(a_test_full_face, (state_reg != ST_RD0) || (stat.count >= CNTW'(3)), "short face test")
    `FOP_ASSERT(a_edge_in_face, (state_reg != ST_ERD) || ({1'b0, edge_reg} < stat.count), "edge index")
    `FOP_ASSERT_NEXT(a_result_shown, out_load, out_valid_reg && (state_reg == ST_IDLE), "result lost")

endmodule

// ===== src/face_occlusion_point_test.sv =====
// ------------------------------------------------------------------------
// face_occlusion_point_test
// Loads the vertices of one polygon face and tests points for occlusion.
// ------------------------------------------------------------------------
// item_in carries vertex loads (action 0, new_face restarts the face) and
// point tests (action 1); coordinates are signed Q16.16. result_out gets one
// transaction per point test: visible, or face_error when the face holds
// fewer than three vertices. cfg writes above_tolerance at any idle time.
// A vertex load is stored in the cycle it is accepted. A point test runs on
// one shared 144 x 8 bit digit-serial multiply-accumulate unit: the plane
// test first, then, unless it passes, the face edges in turn, up to 32 on a
// full face (per edge a vertex read, or the first vertex on the closing edge,
// and four products); an edge hit ends the walk early. A short face answers
// without the unit. One item is worked at a time. Reset empties the face and
// sets the tolerance to 7. The result register holds a finished transaction
// while result_out stalls, and item_in keeps accepting vertex loads
// meanwhile; a second finished test waits until the register is free.
// ------------------------------------------------------------------------
module face_occlusion_point_test
    import fop_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fop_in_if.sink       item_in,
    fop_out_if.source    result_out,
    fop_cfg_if.sink      cfg
);

    fop_cmd_t  cmd;
    fop_stat_t stat;

    assign cfg.ready = 1'b1;

    fop_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (item_in.valid),
        .in_action      (item_in.action),
        .in_new_face    (item_in.new_face),
        .in_ready       (item_in.ready),
        .stat           (stat),
        .cmd            (cmd),
        .out_valid      (result_out.valid),
        .out_visible    (result_out.visible),
        .out_face_error (result_out.face_error),
        .out_ready      (result_out.ready)
    );

    fop_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .coord_x  (item_in.coord_x),
        .coord_y  (item_in.coord_y),
        .coord_z  (item_in.coord_z),
        .cfg_we   (cfg.valid),
        .cfg_data (cfg.above_tolerance),
        .stat     (stat)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for face_occlusion_point_test. It loads polygon faces and
// tests points against them, including short, degenerate, flat, extreme and
// full faces, under random idling on both channels. A behavioral occlusion
// model predicts each result, and a scoreboard compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
    import fop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] span_t;
    typedef struct packed {
        logic visible;
        logic face_error;
    } verdict_t;

    localparam bit ACT_LOAD = 1'b0;
    localparam bit ACT_TEST = 1'b1;
    localparam logic [31:0] C_MAX = 32'h7fff_ffff;
    localparam logic [31:0] C_MIN = 32'h8000_0000;

    logic clk;
    logic rst_n;

    fop_in_if  item_in ();
    fop_out_if result_out ();
    fop_cfg_if cfg ();

    face_occlusion_point_test dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg        (cfg)
    );

    // shadow face and tolerance
    longint        face_x [MAX_FACE_VERTICES];
    longint        face_y [MAX_FACE_VERTICES];
    longint        face_z [MAX_FACE_VERTICES];
    int            face_count;
    longint        acc_x, acc_y, acc_z;
    logic [15:0]   tol_shadow;

    verdict_t      verdicts_due [$];
    int            mismatch_count;
    int            items_sent;
    bit            sender_idles;
    bit            receiver_idles;
    int            result_stall;
    int            hold_off;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sign of (ax - bx)(ay - cy) - (ax - cx)(ay - by)
    function automatic int edge_side(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
        span_t p;
        p = span_t'(ax - bx) * span_t'(ay - cy) - span_t'(ax - cx) * span_t'(ay - by);
        return (p < 0) ? -1 : ((p == 0) ? 0 : 1);
    endfunction

    // z distance to plane vs -tolerance, scaled by S to avoid division
    function automatic bit plane_above(longint px, longint py, longint pz);
        span_t x01, y01, z01, x12, y12, z12, l, m, n, d, s;
        x01 = span_t'(face_x[0] - face_x[1]);
        y01 = span_t'(face_y[0] - face_y[1]);
        z01 = span_t'(face_z[0] - face_z[1]);
        x12 = span_t'(face_x[1] - face_x[2]);
        y12 = span_t'(face_y[1] - face_y[2]);
        z12 = span_t'(face_z[1] - face_z[2]);
        l = y01 * z12 - y12 * z01;
        m = z01 * x12 - z12 * x01;
        n = x01 * y12 - x12 * y01;
        d = l * span_t'(px - face_x[0]) + m * span_t'(py - face_y[0])
            + n * span_t'(pz - face_z[0]);
        s = l * l + m * m + n * n;
        if (s == 0)
            return 1'b0;
        return (n * d + span_t'(tol_shadow) * s) >= 0;
    endfunction

    // update the shadow face; point tests queue the expected verdict
    function automatic void predict_item(bit act, bit nf, logic [31:0] x, logic [31:0] y,
                                         logic [31:0] z);
        longint px, py, pz, cnt;
        int k;
        verdict_t v;
        px = longint'(signed'(x));
        py = longint'(signed'(y));
        pz = longint'(signed'(z));
        if (act == ACT_LOAD)
        begin
            if (nf)
            begin
                face_count = 0;
                acc_x = 0;
                acc_y = 0;
                acc_z = 0;
            end
            if (face_count < MAX_FACE_VERTICES)
            begin
                face_x[face_count] = px;
                face_y[face_count] = py;
                face_z[face_count] = pz;
                acc_x += px;
                acc_y += py;
                acc_z += pz;
                face_count++;
            end
            return;
        end
        v = '0;
        if (face_count < 3)
        begin
            v.face_error = 1'b1;
        end
        else
        begin
            cnt = face_count;
            v.visible = plane_above(px, py, pz);
            for (int i = 0; i < face_count && !v.visible; i++)
            begin
                k = (i + 1 == face_count) ? 0 : i + 1;
                if (edge_side(acc_x, acc_y, cnt * face_x[i], cnt * face_y[i],
                              cnt * face_x[k], cnt * face_y[k])
                    * edge_side(px, py, face_x[i], face_y[i], face_x[k], face_y[k]) <= 0)
                    v.visible = 1'b1;
            end
        end
        verdicts_due.push_back(v);
    endfunction

    // send one transaction; starts and returns at a falling edge
    task automatic send_item(bit act, bit nf, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
        int gap;
        gap = sender_idles ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            item_in.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_in.valid    = 1'b1;
        item_in.action   = act;
        item_in.new_face = nf;
        item_in.coord_x  = x;
        item_in.coord_y  = y;
        item_in.coord_z  = z;
        do @(posedge clk); while (!item_in.ready);
        predict_item(act, nf, x, y, z);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_vertex(bit nf, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_item(ACT_LOAD, nf, x, y, z);
    endtask

    task automatic test_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        send_item(ACT_TEST, 1'($urandom_range(0, 1)), x, y, z);
    endtask

    // wait for all verdicts, then let a trailing vertex load settle
    task automatic drain();
        item_in.valid = 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_tolerance(logic [15:0] value);
        drain();
        cfg.valid           = 1'b1;
        cfg.above_tolerance = value;
        do @(posedge clk); while (!cfg.ready);
        tol_shadow = value;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // receiver: random stall per result plus an optional long hold-off
    initial
    begin
        result_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                result_out.ready = 1'b0;
                hold_off--;
            end
            else if (result_stall > 0)
            begin
                result_out.ready = 1'b0;
                result_stall--;
            end
            else
                result_out.ready = rst_n;
        end
    end

    // scoreboard
    always @(posedge clk)
    begin
        verdict_t got, want;
        if (rst_n && result_out.valid && result_out.ready)
        begin
            got.visible    = result_out.visible;
            got.face_error = result_out.face_error;
            result_stall   = receiver_idles ? $urandom_range(0, 11) : 0;
            if (verdicts_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result visible=%0b face_error=%0b",
                             got.visible, got.face_error);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (got != want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected visible=%0b face_error=%0b, got visible=%0b face_error=%0b",
                                 want.visible, want.face_error, got.visible, got.face_error);
                end
            end
        end
    end

    // coordinate mix: mostly small, some full range and extremes
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: case ($urandom_range(0, 3))
                   0: return C_MAX;
                   1: return C_MIN;
                   2: return 32'h0;
                   default: return 32'hffff_ffff;
               endcase
            default: return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
        endcase
    endfunction

    // fewer than three vertices
    task automatic test_short_face();
        test_point(32'h0, 32'h0, 32'h0);
        load_vertex(1'b1, 32'h0001_0000, 32'h0, 32'h0);
        test_point(32'h0, 32'h0, C_MIN);
        load_vertex(1'b0, 32'h0, 32'h0001_0000, 32'h0);
        test_point(C_MAX, C_MAX, C_MAX);
    endtask

    // extreme coordinates in vertices and points
    task automatic test_extremes();
        load_vertex(1'b1, C_MAX, C_MAX, C_MAX);
        load_vertex(1'b0, C_MIN, C_MIN, C_MIN);
        load_vertex(1'b0, C_MAX, C_MIN, 32'h0);
        test_point(C_MIN, C_MAX, C_MIN);
        test_point(C_MAX, C_MAX, C_MAX);
        test_point(32'hffff_ffff, 32'h0, C_MIN);
    endtask

    // collinear first vertices: plane test never passes, edges decide
    task automatic test_degenerate_plane();
        load_vertex(1'b1, 32'h0, 32'h0, 32'h0);
        load_vertex(1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        load_vertex(1'b0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        test_point(32'h0001_0000, 32'h0, C_MIN);
    endtask

    // flat triangle at z = 0: hidden, within tolerance, on an edge, outside
    task automatic test_flat_face();
        load_vertex(1'b1, 32'hfffe_0000, 32'hfffe_0000, 32'h0);
        load_vertex(1'b0, 32'h0002_0000, 32'hfffe_0000, 32'h0);
        load_vertex(1'b0, 32'h0, 32'h0002_0000, 32'h0);
        test_point(32'h0, 32'h0, 32'hffff_0000);
        test_point(32'h0, 32'h0, 32'hffff_fff9);
        test_point(32'h0, 32'h0, 32'hffff_fff8);
        test_point(32'h0, 32'hfffe_0000, 32'hffff_0000);
        test_point(32'h0005_0000, 32'h0, 32'hffff_0000);
    endtask

    // hold results back long enough that the input channel stalls
    task automatic test_backpressure();
        @(posedge clk);
        hold_off = 600;
        @(negedge clk);
        load_vertex(1'b1, 32'h0, 32'h0, 32'h0001_0000);
        load_vertex(1'b0, 32'h0003_0000, 32'h0, 32'h0001_0000);
        load_vertex(1'b0, 32'h0, 32'h0003_0000, 32'h0001_0000);
        repeat (5)
            test_point(32'h0001_0000, 32'h0001_0000, rand_coord());
        load_vertex(1'b0, 32'hffff_0000, 32'h0001_0000, 32'h0001_0000);
        test_point(32'h0, 32'h0, 32'h0);
    endtask

    // well-formed faces with points near them, plus short and overfull faces
    task automatic test_random_faces(int quota);
        int target, nverts, npoints, pick;
        logic [31:0] cx, cy, zb, r;
        bit flat;
        target = items_sent + quota;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 39);
            nverts = (pick == 0) ? 34 : (pick < 4) ? $urandom_range(0, 2)
                                                   : $urandom_range(3, 6);
            cx   = rand_coord();
            cy   = rand_coord();
            zb   = rand_coord();
            r    = 32'($urandom_range(1, 2 ** 18));
            flat = $urandom_range(0, 1);
            for (int i = 0; i < nverts; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    load_vertex(i == 0, rand_coord(), rand_coord(), rand_coord());
                else
                    load_vertex(i == 0,
                                cx + r * 32'($urandom_range(0, 4)) - 2 * r,
                                cy + r * 32'($urandom_range(0, 4)) - 2 * r,
                                flat ? zb : zb + 32'($urandom_range(0, 4095)));
            end
            npoints = $urandom_range(1, 4);
            for (int j = 0; j < npoints; j++)
            begin
                case ($urandom_range(0, 3))
                    0: test_point(rand_coord(), rand_coord(), rand_coord());
                    1: test_point(cx, cy, zb - 32'($urandom_range(0, 16)));
                    default: test_point(cx + 32'($urandom_range(0, 4)) * r - 2 * r,
                                        cy + 32'($urandom_range(0, 4)) * r - 2 * r,
                                        zb + 32'($urandom_range(0, 2 ** 16)) - 32'(2 ** 15));
                endcase
            end
        end
    endtask

    // stimulus
    initial
    begin
        rst_n               = 1'b0;
        item_in.valid       = 1'b0;
        item_in.action      = ACT_LOAD;
        item_in.new_face    = 1'b0;
        item_in.coord_x     = '0;
        item_in.coord_y     = '0;
        item_in.coord_z     = '0;
        cfg.valid           = 1'b0;
        cfg.above_tolerance = '0;
        face_count          = 0;
        acc_x               = 0;
        acc_y               = 0;
        acc_z               = 0;
        tol_shadow          = TOL_RESET;
        mismatch_count      = 0;
        items_sent          = 0;
        sender_idles        = 1'b1;
        receiver_idles      = 1'b1;
        result_stall        = 0;
        hold_off            = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_short_face();
        test_extremes();
        test_degenerate_plane();
        test_flat_face();
        test_backpressure();

        write_tolerance(16'h0);
        test_flat_face();
        test_random_faces(300);
        write_tolerance(16'hffff);
        test_flat_face();
        test_random_faces(300);
        write_tolerance(16'($urandom));
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        test_random_faces(300);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        write_tolerance(16'h1);
        test_random_faces(300);
        write_tolerance(TOL_RESET);
        test_random_faces(300);

        drain();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/fop_pkg.sv
src/fop_ifs.sv
src/fop_datapath.sv
src/fop_ctrl.sv
src/face_occlusion_point_test.sv
tb/testbench.sv
